// ----- rtl/bglf_pkg.sv -----
// Shared types, constants and register codes for the battery gauge block.
package bglf_pkg;

    // default build
    localparam int DEF_WINDOW_DEPTH = 16;
    localparam int DEF_SAMPLE_BITS  = 12;

    // fixed field widths
    localparam int THR_BITS       = 12;
    localparam int MS_BITS        = 16;
    localparam int TIME_BITS      = 32;
    localparam int AVG_BITS       = 12;
    localparam int PCT_BITS       = 7;
    localparam int OUT_TDATA_BITS = 24;

    // 90 * 4095 fits in 19 bits
    localparam int NUM_BITS = 19;

    localparam int QUEUE_DEPTH = 2;

    // APB port
    localparam int ADDR_BITS    = 5;
    localparam int DATA_BITS    = 32;
    localparam int REG_IDX_BITS = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_FULL_THR    = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_EMPTY_THR   = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_REPORT_INT  = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_FLASH_PER   = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_FLASH_START = 3'd4;

    // percentage scale
    localparam logic [PCT_BITS-1:0] PCT_FULL  = 7'd100;
    localparam logic [PCT_BITS-1:0] PCT_NONE  = 7'd0;
    localparam logic [PCT_BITS-1:0] PCT_BASE  = 7'd10;
    localparam int                  PCT_SCALE = 90;

    typedef struct packed {
        logic [THR_BITS-1:0] full_thr;
        logic [THR_BITS-1:0] empty_thr;
        logic [MS_BITS-1:0]  report_int;
        logic [MS_BITS-1:0]  flash_period;
        logic [MS_BITS-1:0]  flash_start;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        full_thr:     12'd2200,
        empty_thr:    12'd1750,
        report_int:   16'd1000,
        flash_period: 16'd1000,
        flash_start:  16'd900
    };

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_MEAN,
        BK_EVAL,
        BK_PDIV,
        BK_DONE
    } bk_state_t;

endpackage

// ----- rtl/bglf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module bglf_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/bglf_div.sv -----
// Restoring divider, one quotient bit per cycle.
module bglf_div #(
    parameter int N_BITS = 19,
    parameter int D_BITS = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [N_BITS-1:0] dividend,
    input  logic [D_BITS-1:0] divisor,
    output logic              done,
    output logic [N_BITS-1:0] quotient
);

    localparam int CNT_BITS = $clog2(N_BITS + 1);

    logic                busy_reg, busy_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [D_BITS-1:0]   rem_reg, rem_next;
    logic [N_BITS-1:0]   quo_reg, quo_next;
    logic [D_BITS-1:0]   dvs_reg, dvs_next;

    logic [D_BITS:0] rem_sh;
    logic [D_BITS:0] rem_sub;
    logic            ge;

    assign rem_sh   = {rem_reg, quo_reg[N_BITS-1]};
    assign rem_sub  = rem_sh - {1'b0, dvs_reg};
    assign ge       = rem_sh >= {1'b0, dvs_reg};
    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(N_BITS);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
                rem_next = ge ? rem_sub[D_BITS-1:0] : rem_sh[D_BITS-1:0];
                quo_next = {quo_reg[N_BITS-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

// ----- rtl/bglf_front.sv -----
// Input side: takes sample beats, unpacks the fields and queues them for the back end.
module bglf_front #(
    parameter int SAMPLE_BITS = bglf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                                      clk,
    input  logic                                                      rst_n,
    input  logic                                                      s_tvalid,
    output logic                                                      s_tready,
    // adc_sample, time_ms, link_connected (low bit up), zero padded
    input  logic [((SAMPLE_BITS + bglf_pkg::TIME_BITS + 8) / 8) * 8 - 1:0] s_tdata,
    output logic                                                      q_valid,
    input  logic                                                      q_pop,
    output logic [SAMPLE_BITS-1:0]                                    q_sample,
    output logic [bglf_pkg::TIME_BITS-1:0]                            q_time,
    output logic                                                      q_link
);

    import bglf_pkg::*;

    localparam int ITEM_BITS = SAMPLE_BITS + TIME_BITS + 1;
    localparam int PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    logic [ITEM_BITS-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 push;
    logic                 pop;
    logic [ITEM_BITS-1:0] head;

    assign s_tready = cnt_reg != CNT_BITS'(QUEUE_DEPTH);
    assign q_valid  = cnt_reg != '0;
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    assign head     = entry_reg[rd_ptr_reg];
    assign q_sample = head[SAMPLE_BITS-1:0];
    assign q_time   = head[SAMPLE_BITS +: TIME_BITS];
    assign q_link   = head[ITEM_BITS-1];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= s_tdata[ITEM_BITS-1:0];
        end
    end

endmodule

// ----- rtl/bglf_back.sv -----
// Back end: ring update, averaging, report and flash logic, output register.
module bglf_back #(
    parameter int WINDOW_DEPTH = bglf_pkg::DEF_WINDOW_DEPTH,
    parameter int SAMPLE_BITS  = bglf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bglf_pkg::cfg_t                      cfg,
    input  logic                                q_valid,
    output logic                                q_pop,
    input  logic [SAMPLE_BITS-1:0]              q_sample,
    input  logic [bglf_pkg::TIME_BITS-1:0]      q_time,
    input  logic                                q_link,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bglf_pkg::OUT_TDATA_BITS-1:0] m_tdata
);

    import bglf_pkg::*;

    localparam int SLOT_BITS  = $clog2(WINDOW_DEPTH);
    localparam int SUM_BITS   = SAMPLE_BITS + SLOT_BITS;
    localparam int RND_BITS   = SUM_BITS + 1;
    localparam int CMP_BITS   = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
    localparam int DIV_N      = NUM_BITS;
    localparam int DIV_D      = THR_BITS;
    localparam bit DEPTH_POW2 = (WINDOW_DEPTH & (WINDOW_DEPTH - 1)) == 0;

    // mean by reciprocal: ceil(2^(RND_BITS+SLOT_BITS) / depth) is exact for
    // every dividend below 2^RND_BITS
    localparam int     RCP_SHIFT = RND_BITS + SLOT_BITS;
    localparam int     RCP_BITS  = RND_BITS + 2;
    localparam int     PROD_BITS = RND_BITS + RCP_BITS;
    localparam longint RCP       = ((longint'(1) <<< RCP_SHIFT) + longint'(WINDOW_DEPTH) - 1) /
                                   longint'(WINDOW_DEPTH);

    bk_state_t state_reg, state_next;

    logic [SLOT_BITS-1:0]    slot_reg, slot_next;
    logic [SUM_BITS-1:0]     sum_reg, sum_next;
    logic [WINDOW_DEPTH-1:0] vld_reg, vld_next;
    logic [TIME_BITS-1:0]    last_rep_reg, last_rep_next;
    logic [TIME_BITS-1:0]    mark_reg, mark_next;
    logic                    out_valid_reg, out_valid_next;

    logic [SAMPLE_BITS-1:0]    smp_reg, smp_next;
    logic [TIME_BITS-1:0]      time_reg, time_next;
    logic                      link_reg, link_next;
    logic [SAMPLE_BITS-1:0]    mean_reg, mean_next;
    logic                      low_reg, low_next;
    logic                      rep_reg, rep_next;
    logic [PCT_BITS-1:0]       pct_reg, pct_next;
    logic                      led_reg, led_next;
    logic                      neg_reg, neg_next;
    logic [OUT_TDATA_BITS-1:0] out_data_reg, out_data_next;

    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic                   ram_we;
    logic [SAMPLE_BITS-1:0] old_smp;
    logic [RND_BITS-1:0]    rounded;
    logic [SAMPLE_BITS-1:0] mean_shift;
    logic [PROD_BITS-1:0]   mean_prod;
    logic [SAMPLE_BITS-1:0] mean_rcp;

    logic [CMP_BITS-1:0]  mean_ext;
    logic [CMP_BITS-1:0]  full_ext;
    logic [CMP_BITS-1:0]  empty_ext;
    logic [CMP_BITS-1:0]  diff_w;
    logic [THR_BITS-1:0]  diff;
    logic [THR_BITS-1:0]  span;
    logic [NUM_BITS-1:0]  num;
    logic                 below_empty;
    logic [TIME_BITS-1:0] elapsed;
    logic [TIME_BITS-1:0] d_old;
    logic [TIME_BITS-1:0] d_now;
    logic                 low_now;
    logic                 mark_due;
    logic                 flash_now;

    logic             div_start;
    logic [DIV_N-1:0] div_dividend;
    logic [DIV_D-1:0] div_divisor;
    logic             div_done;
    logic [DIV_N-1:0] div_quo;

    bglf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (smp_reg),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    bglf_div #(
        .N_BITS (DIV_N),
        .D_BITS (DIV_D)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // unwritten slots read as zero
    assign old_smp    = vld_reg[slot_reg] ? ram_rdata : '0;
    assign rounded    = RND_BITS'(sum_reg) + RND_BITS'(WINDOW_DEPTH / 2);
    assign mean_shift = rounded[SLOT_BITS +: SAMPLE_BITS];
    assign mean_prod  = PROD_BITS'(rounded) * PROD_BITS'(RCP_BITS'(RCP));
    assign mean_rcp   = mean_prod[RCP_SHIFT +: SAMPLE_BITS];

    assign mean_ext    = CMP_BITS'(mean_reg);
    assign full_ext    = CMP_BITS'(cfg.full_thr);
    assign empty_ext   = CMP_BITS'(cfg.empty_thr);
    assign below_empty = mean_ext < empty_ext;
    assign diff_w      = below_empty ? (empty_ext - mean_ext) : (mean_ext - empty_ext);
    assign diff        = diff_w[THR_BITS-1:0];
    assign span        = cfg.full_thr - cfg.empty_thr;
    assign num         = NUM_BITS'(PCT_SCALE) * NUM_BITS'(diff);

    assign elapsed   = time_reg - last_rep_reg;
    assign low_now   = mean_ext <= empty_ext;
    assign d_old     = time_reg - mark_reg;
    assign mark_due  = d_old > TIME_BITS'(cfg.flash_period);
    // mark restarts (d = 0), holds (d = d_old) or is cleared (d = time)
    assign d_now     = !low_now ? time_reg : (mark_due ? '0 : d_old);
    assign flash_now = (d_now >= TIME_BITS'(cfg.flash_start)) &&
                       (d_now <= TIME_BITS'(cfg.flash_period));

    assign ram_we   = state_reg == BK_READ;
    assign q_pop    = (state_reg == BK_IDLE) && q_valid;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        sum_next       = sum_reg;
        vld_next       = vld_reg;
        last_rep_next  = last_rep_reg;
        mark_next      = mark_reg;
        smp_next       = smp_reg;
        time_next      = time_reg;
        link_next      = link_reg;
        mean_next      = mean_reg;
        low_next       = low_reg;
        rep_next       = rep_reg;
        pct_next       = pct_reg;
        led_next       = led_reg;
        neg_next       = neg_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        div_start      = 1'b0;
        div_dividend   = DIV_N'(num);
        div_divisor    = DIV_D'(span);

        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    smp_next   = q_sample;
                    time_next  = q_time;
                    link_next  = q_link;
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                sum_next           = sum_reg - SUM_BITS'(old_smp) + SUM_BITS'(smp_reg);
                vld_next[slot_reg] = 1'b1;
                slot_next          = (slot_reg == SLOT_BITS'(WINDOW_DEPTH - 1)) ?
                                     '0 : slot_reg + 1'b1;
                state_next         = BK_MEAN;
            end
            BK_MEAN:
            begin
                mean_next  = DEPTH_POW2 ? mean_shift : mean_rcp;
                state_next = BK_EVAL;
            end
            BK_EVAL:
            begin
                low_next   = low_now;
                led_next   = link_reg ? flash_now : !flash_now;
                mark_next  = !low_now ? '0 : (mark_due ? time_reg : mark_reg);
                rep_next   = elapsed > TIME_BITS'(cfg.report_int);
                pct_next   = PCT_NONE;
                neg_next   = below_empty;
                state_next = BK_DONE;
                if (elapsed > TIME_BITS'(cfg.report_int))
                begin
                    last_rep_next = time_reg;
                    if (mean_ext >= full_ext)
                    begin
                        pct_next = PCT_FULL;
                    end
                    else if (cfg.full_thr > cfg.empty_thr)
                    begin
                        div_start  = 1'b1;
                        state_next = BK_PDIV;
                    end
                end
            end
            BK_PDIV:
            begin
                if (div_done)
                begin
                    if (neg_reg)
                    begin
                        pct_next = (div_quo >= DIV_N'(PCT_BASE)) ?
                                   PCT_NONE : PCT_BASE - div_quo[PCT_BITS-1:0];
                    end
                    else
                    begin
                        pct_next = PCT_BASE + div_quo[PCT_BITS-1:0];
                    end
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_TDATA_BITS'({led_reg, pct_reg, rep_reg, low_reg,
                                                      mean_ext[AVG_BITS-1:0]});
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            slot_reg      <= '0;
            sum_reg       <= '0;
            vld_reg       <= '0;
            last_rep_reg  <= '0;
            mark_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            sum_reg       <= sum_next;
            vld_reg       <= vld_next;
            last_rep_reg  <= last_rep_next;
            mark_reg      <= mark_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg      <= smp_next;
        time_reg     <= time_next;
        link_reg     <= link_next;
        mean_reg     <= mean_next;
        low_reg      <= low_next;
        rep_reg      <= rep_next;
        pct_reg      <= pct_next;
        led_reg      <= led_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ----- rtl/battery_gauge_with_low_flash_core.sv -----
// Top level of the battery gauge: APB registers, input queue and processing back end.
//
// Battery gauge with low-battery LED flash. Each input beat carries one
// converter sample, the millisecond time and the link-connected flag; each
// one gives exactly one output beat with the rounded mean of the last
// WINDOW_DEPTH samples, the low flag, an optional charge percentage and the
// LED drive. A beat passes the back end through pop, ring update, mean,
// evaluate and output, with a serial divide by (full - empty) when a
// percentage report needs it, one bit of the 19-bit dividend at a time,
// then handing back the quotient. The restoring divider sets a beat's worst case.
// The mean is a shift, or a reciprocal multiply when WINDOW_DEPTH is not a
// power of two, and needs no divider. A two-beat input queue lets the sender
// run ahead of the back end, and the output register lets the back end
// finish a beat while the previous result waits. The sample ring is a RAM
// with one valid flag per slot, cleared at reset, so no clearing pass is
// needed. Registers must be written only while idle; the block does not enforce it.
module battery_gauge_with_low_flash_core #(
    parameter int WINDOW_DEPTH = bglf_pkg::DEF_WINDOW_DEPTH,
    parameter int SAMPLE_BITS  = bglf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                                      clk,
    input  logic                                                      rst_n,
    // APB configuration port
    input  logic                                                      psel,
    input  logic                                                      penable,
    input  logic                                                      pwrite,
    input  logic [bglf_pkg::ADDR_BITS-1:0]                            paddr,
    input  logic [bglf_pkg::DATA_BITS-1:0]                            pwdata,
    output logic [bglf_pkg::DATA_BITS-1:0]                            prdata,
    output logic                                                      pready,
    // sample stream
    input  logic                                                      s_tvalid,
    output logic                                                      s_tready,
    // adc_sample, time_ms, link_connected (low bit up), zero padded
    input  logic [((SAMPLE_BITS + bglf_pkg::TIME_BITS + 8) / 8) * 8 - 1:0] s_tdata,
    // result stream
    output logic                                                      m_tvalid,
    input  logic                                                      m_tready,
    // average_level, battery_low, report_valid, battery_percent, led_lit
    // (low bit up), zero padded
    output logic [bglf_pkg::OUT_TDATA_BITS-1:0]                       m_tdata
);

    import bglf_pkg::*;

    cfg_t cfg_reg, cfg_next;

    logic                    cfg_wr;
    logic [REG_IDX_BITS-1:0] cfg_idx;

    logic                   q_valid;
    logic                   q_pop;
    logic [SAMPLE_BITS-1:0] q_sample;
    logic [TIME_BITS-1:0]   q_time;
    logic                   q_link;

    // ---------------------------------------------------------------
    // Register file: index = paddr / 4, unused indexes ignored
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ADDR_BITS-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                REG_FULL_THR:    cfg_next.full_thr     = pwdata[THR_BITS-1:0];
                REG_EMPTY_THR:   cfg_next.empty_thr    = pwdata[THR_BITS-1:0];
                REG_REPORT_INT:  cfg_next.report_int   = pwdata[MS_BITS-1:0];
                REG_FLASH_PER:   cfg_next.flash_period = pwdata[MS_BITS-1:0];
                REG_FLASH_START: cfg_next.flash_start  = pwdata[MS_BITS-1:0];
                default:         cfg_next              = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_FULL_THR:    prdata = DATA_BITS'(cfg_reg.full_thr);
            REG_EMPTY_THR:   prdata = DATA_BITS'(cfg_reg.empty_thr);
            REG_REPORT_INT:  prdata = DATA_BITS'(cfg_reg.report_int);
            REG_FLASH_PER:   prdata = DATA_BITS'(cfg_reg.flash_period);
            REG_FLASH_START: prdata = DATA_BITS'(cfg_reg.flash_start);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------------------------------------------------------
    // Front: accept beats, unpack, queue
    // ---------------------------------------------------------------
    bglf_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_sample (q_sample),
        .q_time   (q_time),
        .q_link   (q_link)
    );

    // ---------------------------------------------------------------
    // Back: ring, mean, report, flash, output register
    // ---------------------------------------------------------------
    bglf_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_sample (q_sample),
        .q_time   (q_time),
        .q_link   (q_link),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTH
    // a full queue always has a beat for the back end
    a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> q_valid)
        else $error("input queue full but reports no head beat");

    // no report means a zero percentage field
    a_pct_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[13] || (m_tdata[20:14] == 7'd0)))
        else $error("percentage set without a report");

    // percentage never above full scale
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[20:14] <= 7'd100))
        else $error("percentage above 100");
`endif

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the battery gauge core: streamed samples, APB set-up, result checks.
`timescale 1ns / 1ps

module tb_top;

    import bglf_pkg::*;

    // Reading the block is expected to give for one sample beat
    typedef struct {
        logic [AVG_BITS-1:0] average_level;
        logic                battery_low;
        logic                report_valid;
        logic [PCT_BITS-1:0] battery_percent;
        logic                led_lit;
    } gauge_reading_t;

    localparam int IN_TDATA_BITS = ((DEF_SAMPLE_BITS + TIME_BITS + 8) / 8) * 8;

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     psel     = 1'b0;
    logic                     penable  = 1'b0;
    logic                     pwrite   = 1'b0;
    logic [ADDR_BITS-1:0]     paddr    = '0;
    logic [DATA_BITS-1:0]     pwdata   = '0;
    logic [DATA_BITS-1:0]     prdata;
    logic                     pready;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    // adc_sample [11:0], time_ms [43:12], link_connected [44], zero pad [47:45]
    logic [IN_TDATA_BITS-1:0] s_tdata  = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    // average_level [11:0], battery_low [12], report_valid [13],
    // battery_percent [20:14], led_lit [21], zero pad [23:22]
    logic [OUT_TDATA_BITS-1:0] m_tdata;

    // Idling switches, flipped per test so that some stretches run flat out
    bit src_idle  = 1'b0;
    bit sink_idle = 1'b0;
    int error_count = 0;

    // Gauge state as the testbench sees it
    cfg_t                     gauge_cfg      = CFG_RESET;
    logic [DEF_SAMPLE_BITS-1:0] sample_hist [DEF_WINDOW_DEPTH] = '{default: '0};
    logic [3:0]               hist_slot      = '0;
    logic [15:0]              window_sum     = '0;
    logic [TIME_BITS-1:0]     last_report_ms = '0;
    logic [TIME_BITS-1:0]     flash_mark_ms  = '0;

    // Readings in flight, oldest at the front
    gauge_reading_t pending_readings [$];

    battery_gauge_with_low_flash_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    // Generous fixed time limit on the whole run
    initial
    begin
        #30_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Charge percentage for a mean, from the current thresholds.
    // Truncation toward zero on a negative numerator matches SV division.
    function automatic logic [PCT_BITS-1:0] charge_percent(input logic [AVG_BITS-1:0] mean);
        longint span;
        longint num;
        longint pct;
        if (mean >= gauge_cfg.full_thr)
            return PCT_FULL;
        // inverted or equal thresholds: no divide, reports zero
        if (gauge_cfg.full_thr <= gauge_cfg.empty_thr)
            return PCT_NONE;
        span = longint'(gauge_cfg.full_thr) - longint'(gauge_cfg.empty_thr);
        num  = PCT_SCALE * (longint'(mean) - longint'(gauge_cfg.empty_thr));
        pct  = longint'(PCT_BASE) + num / span;
        if (pct < 0)
            pct = 0;
        if (pct > 100)
            pct = 100;
        return pct[PCT_BITS-1:0];
    endfunction

    // Advances the gauge by one sample and returns the reading it gives
    function automatic gauge_reading_t gauge_predict(input logic [DEF_SAMPLE_BITS-1:0] adc,
                                                     input logic [TIME_BITS-1:0] now,
                                                     input logic link);
        gauge_reading_t r;
        logic [16:0]          rounded;
        logic [TIME_BITS-1:0] since_report;
        logic [TIME_BITS-1:0] since_mark;
        logic                 flash;
        window_sum             = window_sum - 16'(sample_hist[hist_slot]) + 16'(adc);
        sample_hist[hist_slot] = adc;
        hist_slot              = hist_slot + 4'd1;

        rounded         = {1'b0, window_sum} + 17'd8;
        r.average_level = rounded[15:4];

        since_report      = now - last_report_ms;
        r.report_valid    = since_report > TIME_BITS'(gauge_cfg.report_int);
        r.battery_percent = PCT_NONE;
        if (r.report_valid)
        begin
            r.battery_percent = charge_percent(r.average_level);
            last_report_ms    = now;
        end

        r.battery_low = r.average_level <= gauge_cfg.empty_thr;

        // Low keeps the flash mark running; otherwise it is held at zero,
        // so the window then follows the raw time.
        if (r.battery_low)
        begin
            since_mark = now - flash_mark_ms;
            if (since_mark > TIME_BITS'(gauge_cfg.flash_period))
                flash_mark_ms = now;
        end
        else
            flash_mark_ms = '0;

        since_mark = now - flash_mark_ms;
        flash      = (since_mark >= TIME_BITS'(gauge_cfg.flash_start)) &&
                     (since_mark <= TIME_BITS'(gauge_cfg.flash_period));
        r.led_lit  = link ? flash : ~flash;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and field checks
    // ------------------------------------------------------------------

    int stall_left = 0;

    always @(posedge clk)
    begin
        gauge_reading_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_readings.size() == 0)
                begin
                    $error("result beat with no reading pending: tdata %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (m_tdata[11:0] !== want.average_level)
                    begin
                        $error("average_level expected %0d got %0d",
                               want.average_level, m_tdata[11:0]);
                        error_count++;
                    end
                    if (m_tdata[12] !== want.battery_low)
                    begin
                        $error("battery_low expected %0b got %0b", want.battery_low, m_tdata[12]);
                        error_count++;
                    end
                    if (m_tdata[13] !== want.report_valid)
                    begin
                        $error("report_valid expected %0b got %0b", want.report_valid, m_tdata[13]);
                        error_count++;
                    end
                    if (m_tdata[20:14] !== want.battery_percent)
                    begin
                        $error("battery_percent expected %0d got %0d",
                               want.battery_percent, m_tdata[20:14]);
                        error_count++;
                    end
                    if (m_tdata[21] !== want.led_lit)
                    begin
                        $error("led_lit expected %0b got %0b", want.led_lit, m_tdata[21]);
                        error_count++;
                    end
                end
                // fresh stall for the next beat
                stall_left = sink_idle ? $urandom_range(0, 12) : 0;
                m_tready  <= (stall_left == 0);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= (stall_left == 0);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Shared driver tasks
    // ------------------------------------------------------------------

    // One sample beat; valid is only lowered when a gap is taken, so
    // back-to-back beats keep it high
    task automatic send_sample(input logic [DEF_SAMPLE_BITS-1:0] adc,
                               input logic [TIME_BITS-1:0] now, input logic link);
        int gap;
        gap = src_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pending_readings.push_back(gauge_predict(adc, now, link));
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, link, now, adc};
        do @(posedge clk); while (!s_tready);
    endtask

    // Stops the stream and waits until every pending reading has come back.
    // Every beat gives a reading, so the block is idle once this returns.
    task automatic drain_readings();
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
    endtask

    // Setup then access; bits above the register width carry junk to
    // exercise the masking
    task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                             input logic [DATA_BITS-1:0] val, input int bits);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (($urandom() >> bits) << bits) | val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic program_gauge(input logic [THR_BITS-1:0] full_v,
                                 input logic [THR_BITS-1:0] empty_v,
                                 input logic [MS_BITS-1:0]  report_v,
                                 input logic [MS_BITS-1:0]  period_v,
                                 input logic [MS_BITS-1:0]  start_v);
        write_reg(REG_FULL_THR,    DATA_BITS'(full_v),   THR_BITS);
        write_reg(REG_EMPTY_THR,   DATA_BITS'(empty_v),  THR_BITS);
        write_reg(REG_REPORT_INT,  DATA_BITS'(report_v), MS_BITS);
        write_reg(REG_FLASH_PER,   DATA_BITS'(period_v), MS_BITS);
        write_reg(REG_FLASH_START, DATA_BITS'(start_v),  MS_BITS);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        gauge_cfg.full_thr     = full_v;
        gauge_cfg.empty_thr    = empty_v;
        gauge_cfg.report_int   = report_v;
        gauge_cfg.flash_period = period_v;
        gauge_cfg.flash_start  = start_v;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset thresholds with an empty ring: no report at time zero, a report
    // clamped to zero percent, low flash window, both link senses
    task automatic test_reset_defaults();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        send_sample(12'd0,    32'd0,    1'b0);
        send_sample(12'd0,    32'd1001, 1'b1);
        send_sample(12'hFFF,  32'd1950, 1'b1);
        send_sample(12'hFFF,  32'd2100, 1'b0);
    endtask

    // Fills the ring with full-scale samples so the slot wraps, with time
    // running across the 2^32 wrap; then a high mean with the flash mark
    // cleared, where the window follows the raw time
    task automatic test_ring_and_time_wrap();
        int i;
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        send_sample(12'hFFF, 32'hFFFF_FFFF, 1'b0);
        for (i = 0; i < 15; i++)
            send_sample(12'hFFF, 32'hFFFF_FC00 + 32'(i * 150), i[0]);
        send_sample(12'hFFF, 32'd950, 1'b1);
    endtask

    // Inverted and then equal thresholds with the mean below full
    task automatic test_threshold_corners();
        src_idle  = 1'b0;
        sink_idle = 1'b1;
        drain_readings();
        program_gauge(12'd4000, 12'd4095, 16'd0, 16'd1, 16'd0);
        send_sample(12'd0,   32'd5000, 1'b1);
        send_sample(12'hFFF, 32'd5001, 1'b0);
        drain_readings();
        program_gauge(12'd4095, 12'd4095, 16'd0, 16'hFFFF, 16'hFFFF);
        send_sample(12'd0,   32'd6000, 1'b1);
        send_sample(12'hFFF, 32'd6001, 1'b0);
    endtask

    // Phases of plausible battery traces: a level wandering around the
    // thresholds, time mostly moving forward in small steps, with odd
    // jumps, glitchy samples and link drops as noise
    task automatic test_random_phases();
        int phase;
        int n;
        int level;
        int sample;
        logic [THR_BITS-1:0]  full_v;
        logic [THR_BITS-1:0]  empty_v;
        logic [MS_BITS-1:0]   report_v;
        logic [MS_BITS-1:0]   period_v;
        logic [MS_BITS-1:0]   start_v;
        logic [TIME_BITS-1:0] now;
        logic                 link;
        for (phase = 0; phase < 14; phase++)
        begin
            drain_readings();
            case (phase)
                0: program_gauge(12'hFFF, 12'd0,   16'd0,    16'd1,    16'd0);
                1: program_gauge(12'd0,   12'd0,   16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: program_gauge(12'd2200, 12'd1750, 16'd1000, 16'd1000, 16'd900);
                default:
                begin
                    empty_v = THR_BITS'($urandom_range(0, 3500));
                    if ($urandom_range(0, 5) == 0)
                        full_v = THR_BITS'($urandom_range(0, 4095));
                    else
                        full_v = (int'(empty_v) + 600 > 4095) ? 12'hFFF :
                                 empty_v + 12'($urandom_range(1, 600));
                    case ($urandom_range(0, 3))
                        0:       report_v = 16'd0;
                        1:       report_v = MS_BITS'($urandom_range(0, 200));
                        default: report_v = MS_BITS'($urandom_range(0, 3000));
                    endcase
                    period_v = ($urandom_range(0, 4) == 0) ? 16'hFFFF :
                                                             MS_BITS'($urandom_range(1, 3000));
                    start_v  = ($urandom_range(0, 3) == 0) ?
                               MS_BITS'($urandom_range(0, 65535)) :
                               MS_BITS'($urandom_range(0, int'(period_v)));
                    program_gauge(full_v, empty_v, report_v, period_v, start_v);
                end
            endcase
            src_idle  = (phase % 3) != 0;
            sink_idle = (phase % 4) != 1;
            level = int'(gauge_cfg.empty_thr);
            now   = $urandom();
            link  = 1'b1;
            for (n = 0; n < 100; n++)
            begin
                if ($urandom_range(0, 39) == 0)
                    level = $urandom_range(0, 4095);
                else
                    level = level + int'($urandom_range(0, 60)) - 30;
                if (level < 0)
                    level = 0;
                if (level > 4095)
                    level = 4095;
                if ($urandom_range(0, 19) == 0)
                    sample = $urandom_range(0, 4095);
                else
                    sample = level + int'($urandom_range(0, 40)) - 20;
                if (sample < 0)
                    sample = 0;
                if (sample > 4095)
                    sample = 4095;
                // step scaled to the flash period so long periods still wrap round
                if ($urandom_range(0, 24) == 0)
                    now = $urandom();
                else
                    now = now + $urandom_range(0, int'(gauge_cfg.flash_period) / 8 + 60);
                if ($urandom_range(0, 9) == 0)
                    link = ~link;
                send_sample(sample[DEF_SAMPLE_BITS-1:0], now, link);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_ring_and_time_wrap();
        test_threshold_corners();
        test_random_phases();

        // all beats sent: let the tail drain, then allow for the back end
        drain_readings();
        repeat (60) @(posedge clk);

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
